// ----- rtl/core/bmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpd_pkg: shared types and constants of the bitmap pixel stream decoder
// Holds register reset values, format codes and the queue entry type.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int MAX_DIMENSION = 16384;

  localparam logic [1:0] FMT_BGR24 = 2'd0;
  localparam logic [1:0] FMT_BGRA32 = 2'd1;
  localparam logic [1:0] FMT_BITFIELDS = 2'd2;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TOP_DOWN = 3'd2;
  localparam logic [2:0] REG_FORMAT = 3'd3;
  localparam logic [2:0] REG_RED_MASK = 3'd4;
  localparam logic [2:0] REG_GREEN_MASK = 3'd5;
  localparam logic [2:0] REG_BLUE_MASK = 3'd6;
  localparam logic [2:0] REG_ALPHA_MASK = 3'd7;

  localparam logic [31:0] RED_MASK_RST = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RST = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_MASK_RST = 32'hFF00_0000;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // one assembled pixel with its destination, passed front to back
  typedef struct packed {
    logic [31:0] pix;
    logic        bitfields;
    logic        alpha_valid;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } pix_entry_t;

endpackage

// ----- rtl/core/bmpd_front.sv -----
// ----------------------------------------------------------------------------
// bmpd_front: byte assembly, padding skip and position counters
// Accepts one byte per cycle while the queue is not full and pushes one entry per completed pixel.
// ----------------------------------------------------------------------------
module bmpd_front #(
  parameter int MAX_DIM = bmpd_pkg::MAX_DIMENSION
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  logic [7:0]            byte_data,
  output logic                  byte_stall,
  input  logic [14:0]           width_cfg,
  input  logic [14:0]           height_cfg,
  input  logic                  top_down_cfg,
  input  logic [1:0]            format_cfg,
  output logic                  push,
  output bmpd_pkg::pix_entry_t  push_entry,
  input  logic                  q_full
);
  localparam int CW = $clog2(MAX_DIM + 1);

  logic [1:0]  byte_pos_r, pad_left_r;
  logic [23:0] partial_r;
  logic [CW-1:0] col_r, frow_r;
  logic [CW-1:0] w, h, row_sel, row;
  logic [1:0]  last_idx, pad_val;
  logic        take, fmt24, row_end, img_end;
  logic [31:0] pix;

  function automatic logic [CW-1:0] clamp_dim(input logic [14:0] v);
    logic [CW-1:0] r;
    begin
      if (v == 15'd0) r = CW'(1);
      else if ({17'd0, v} > 32'(MAX_DIM)) r = CW'(MAX_DIM);
      else r = CW'(v);
      return r;
    end
  endfunction

  assign w = clamp_dim(width_cfg);
  assign h = clamp_dim(height_cfg);
  assign fmt24 = (format_cfg == bmpd_pkg::FMT_BGR24);
  assign last_idx = fmt24 ? 2'd2 : 2'd3;
  assign byte_stall = q_full;
  assign take = byte_valid && !q_full;

  assign pix = fmt24 ? {8'd0, byte_data, partial_r[15:0]} : {byte_data, partial_r};
  assign row_sel = (frow_r < h) ? frow_r : h - CW'(1);
  assign row = top_down_cfg ? row_sel : h - CW'(1) - row_sel;
  assign row_end = ({1'b0, col_r} + 1'b1) >= {1'b0, w};
  assign img_end = ({1'b0, frow_r} + 1'b1) >= {1'b0, h};
  // padding = (4 - (w*bpp)&3)&3; bpp 4 never pads, bpp 3 gives (4 - w*3 mod 4) mod 4
  assign pad_val = fmt24 ? 2'(3'd4 - 3'(2'(w[1:0] * 2'd3))) : 2'd0;

  assign push = take && pad_left_r == 2'd0 && byte_pos_r >= last_idx;
  always_comb begin
    push_entry = '0;
    push_entry.pix = pix;
    push_entry.bitfields = format_cfg[1];
    push_entry.alpha_valid = (format_cfg == bmpd_pkg::FMT_BGRA32);
    push_entry.row = 16'(row);
    push_entry.col = 16'(col_r);
    push_entry.last = row_end && img_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      pad_left_r <= '0;
      partial_r <= '0;
      col_r <= '0;
      frow_r <= '0;
    end else if (take) begin
      if (pad_left_r != 2'd0) begin
        pad_left_r <= pad_left_r - 2'd1;
      end else if (byte_pos_r < last_idx) begin
        partial_r[8*byte_pos_r +: 8] <= byte_data;
        byte_pos_r <= byte_pos_r + 2'd1;
      end else begin
        byte_pos_r <= '0;
        partial_r <= '0;
        if (row_end) begin
          col_r <= '0;
          pad_left_r <= pad_val;
          frow_r <= img_end ? '0 : frow_r + CW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end
endmodule

// ----- rtl/core/bmpd_queue.sv -----
// ----------------------------------------------------------------------------
// bmpd_queue: two-entry FIFO between front and back
// ----------------------------------------------------------------------------
module bmpd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bmpd_pkg::pix_entry_t push_entry,
  output logic                 full,
  output logic                 not_empty,
  input  logic                 pop,
  output bmpd_pkg::pix_entry_t head
);
  bmpd_pkg::pix_entry_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/bmpd_back.sv -----
// ----------------------------------------------------------------------------
// bmpd_back: channel extraction and bitfield scaling
// Shares one radix-2 divider over the four channels in bitfield mode.
// ----------------------------------------------------------------------------
module bmpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  bmpd_pkg::pix_entry_t head,
  output logic                 pop,
  input  logic [31:0]          red_mask,
  input  logic [31:0]          green_mask,
  input  logic [31:0]          blue_mask,
  input  logic [31:0]          alpha_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  output logic [13:0]          out_dest_row,
  output logic [13:0]          out_dest_col,
  output logic                 out_last_pixel
);
  bmpd_pkg::bk_state_t state_r, state_nxt;
  logic [1:0]  ch_r;
  logic [1:0]  ch_sel;
  logic [5:0]  bit_r;
  logic [39:0] num_r;
  logic [31:0] den_r, rem_r;
  logic [39:0] quo_r;
  logic [7:0]  res_r [4];
  logic [31:0] mask;
  logic [31:0] m_sh, v_sh;
  logic [4:0]  s;
  logic [32:0] trial;
  logic        start, ch_done, out_free;
  logic [39:0] t_calc;

  assign out_free = !out_valid || !out_stall;

  // operands are loaded for the channel that runs next
  assign ch_sel = (state_r == bmpd_pkg::BK_DIV && ch_done) ? ch_r + 2'd1 : ch_r;

  always_comb begin
    unique case (ch_sel)
      2'd0: mask = red_mask;
      2'd1: mask = green_mask;
      2'd2: mask = blue_mask;
      default: mask = alpha_mask;
    endcase
  end

  // trailing-zero count, shift down
  always_comb begin
    s = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) s = 5'(i);
    end
    m_sh = mask >> s;
    v_sh = (head.pix & mask) >> s;
    t_calc = ({8'd0, v_sh} * 40'd255) + {9'd0, m_sh[31:1]};
  end

  assign trial = {rem_r, num_r[39]};
  assign ch_done = (bit_r == 6'd39);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmpd_pkg::BK_IDLE:
        if (q_not_empty && head.bitfields) state_nxt = bmpd_pkg::BK_DIV;
        else if (q_not_empty) state_nxt = bmpd_pkg::BK_DONE;
      bmpd_pkg::BK_DIV:
        if (ch_done && ch_r == 2'd3) state_nxt = bmpd_pkg::BK_DONE;
      bmpd_pkg::BK_DONE:
        if (out_free) state_nxt = bmpd_pkg::BK_IDLE;
      default: state_nxt = bmpd_pkg::BK_IDLE;
    endcase
  end

  assign start = (state_r == bmpd_pkg::BK_IDLE) && q_not_empty;
  assign pop = (state_r == bmpd_pkg::BK_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bmpd_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
      bit_r <= '0;
    end else if (start) begin
      ch_r <= '0;
      bit_r <= '0;
    end else if (state_r == bmpd_pkg::BK_DIV) begin
      bit_r <= ch_done ? 6'd0 : bit_r + 6'd1;
      if (ch_done) ch_r <= ch_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start || (state_r == bmpd_pkg::BK_DIV && ch_done)) begin
      num_r <= t_calc;
      den_r <= m_sh;
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == bmpd_pkg::BK_DIV) begin
      num_r <= {num_r[38:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_r <= 32'(trial - {1'b0, den_r});
        quo_r <= {quo_r[38:0], 1'b1};
      end else begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[38:0], 1'b0};
      end
    end
  end

  // start loads channel 0 operands, so the mask select must be channel 0 then
  always_ff @(posedge clk) begin
    if (state_r == bmpd_pkg::BK_DIV && ch_done) begin
      res_r[ch_r] <= (den_r == 32'd0) ? 8'hFF
                   : (trial >= {1'b0, den_r}) ? {quo_r[6:0], 1'b1} : {quo_r[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.bitfields) begin
        out_red <= res_r[0];
        out_green <= res_r[1];
        out_blue <= res_r[2];
        out_alpha <= res_r[3];
      end else begin
        out_red <= head.pix[23:16];
        out_green <= head.pix[15:8];
        out_blue <= head.pix[7:0];
        out_alpha <= head.alpha_valid ? head.pix[31:24] : 8'hFF;
      end
      out_dest_row <= head.row[13:0];
      out_dest_col <= head.col[13:0];
      out_last_pixel <= head.last;
    end
  end
endmodule

// ----- rtl/core/bmp_pixel_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder_top: bitmap pixel-area stream decoder
// Flow: a 24/32-bit BGR(A) pixel goes from the queue through the back end's
// IDLE and DONE states to the output register; a bitfield pixel also passes
// DIV, where the shared divider scales its 4 channels in turn. Throughput:
// one byte per cycle while the 2-entry queue has room; the back end finishes
// one pixel before it pops the next, so bitfield pixels drain slower.
// Reset (rst_n low, synchronous) clears counters, queue, state and config registers.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder_top #(
  parameter int MAX_DIMENSION = bmpd_pkg::MAX_DIMENSION
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [13:0] out_dest_row,
  output logic [13:0] out_dest_col,
  output logic        out_last_pixel,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // configuration registers
  logic [14:0] width_r, height_r;
  logic        top_down_r;
  logic [1:0]  format_r;
  logic [31:0] red_mask_r, green_mask_r, blue_mask_r, alpha_mask_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  logic                 push, q_full, q_not_empty, pop;
  bmpd_pkg::pix_entry_t push_entry, head;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 15'd1;
      height_r <= 15'd1;
      top_down_r <= 1'b0;
      format_r <= bmpd_pkg::FMT_BGR24;
      red_mask_r <= bmpd_pkg::RED_MASK_RST;
      green_mask_r <= bmpd_pkg::GREEN_MASK_RST;
      blue_mask_r <= bmpd_pkg::BLUE_MASK_RST;
      alpha_mask_r <= bmpd_pkg::ALPHA_MASK_RST;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (reg_idx)
        bmpd_pkg::REG_WIDTH: width_r <= pwdata[14:0];
        bmpd_pkg::REG_HEIGHT: height_r <= pwdata[14:0];
        bmpd_pkg::REG_TOP_DOWN: top_down_r <= pwdata[0];
        bmpd_pkg::REG_FORMAT: format_r <= pwdata[1:0];
        bmpd_pkg::REG_RED_MASK: red_mask_r <= pwdata;
        bmpd_pkg::REG_GREEN_MASK: green_mask_r <= pwdata;
        bmpd_pkg::REG_BLUE_MASK: blue_mask_r <= pwdata;
        default: alpha_mask_r <= pwdata;
      endcase
    end
  end

  // readback
  always_comb begin
    unique case (reg_idx)
      bmpd_pkg::REG_WIDTH: prdata = {17'd0, width_r};
      bmpd_pkg::REG_HEIGHT: prdata = {17'd0, height_r};
      bmpd_pkg::REG_TOP_DOWN: prdata = {31'd0, top_down_r};
      bmpd_pkg::REG_FORMAT: prdata = {30'd0, format_r};
      bmpd_pkg::REG_RED_MASK: prdata = red_mask_r;
      bmpd_pkg::REG_GREEN_MASK: prdata = green_mask_r;
      bmpd_pkg::REG_BLUE_MASK: prdata = blue_mask_r;
      default: prdata = alpha_mask_r;
    endcase
  end

  // front: assemble bytes, skip padding, tag each pixel with its position
  bmpd_front #(.MAX_DIM(MAX_DIMENSION)) u_front (
    .clk, .rst_n,
    .byte_valid(in_valid), .byte_data(in_pixel_byte), .byte_stall(in_stall),
    .width_cfg(width_r), .height_cfg(height_r),
    .top_down_cfg(top_down_r), .format_cfg(format_r),
    .push, .push_entry, .q_full
  );

  // queue: decouple byte intake from the slow bitfield back end
  bmpd_queue u_queue (
    .clk, .rst_n, .push, .push_entry, .full(q_full),
    .not_empty(q_not_empty), .pop, .head
  );

  // back: scale channels and hold the result transaction
  bmpd_back u_back (
    .clk, .rst_n, .q_not_empty, .head, .pop,
    .red_mask(red_mask_r), .green_mask(green_mask_r),
    .blue_mask(blue_mask_r), .alpha_mask(alpha_mask_r),
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_alpha,
    .out_dest_row, .out_dest_col, .out_last_pixel
  );
endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: bitmap pixel stream decoder
// Drives pixel-area bytes through several register settings, predicts each
// decoded RGBA pixel with its destination, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [13:0] row;
    logic [13:0] col;
    logic        last;
  } rgba_pixel_t;

  // One row of the directed table: a byte, and for rows that can be read
  // off at a glance, the pixel it completes.
  typedef struct {
    logic [7:0]  data;
    bit          typed;
    rgba_pixel_t want;
  } byte_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pixel_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [13:0] out_dest_row;
  logic [13:0] out_dest_col;
  logic        out_last_pixel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bmp_pixel_stream_decoder_top dut (.*);

  // Shadow of the registers and the byte-walk state.
  logic [14:0] img_w, img_h;
  logic        img_top_down;
  logic [1:0]  img_fmt;
  logic [31:0] mask_r, mask_g, mask_b, mask_a;
  int unsigned byte_pos, partial, col_cnt, row_cnt, pad_left;

  rgba_pixel_t pending_pixels[$];
  int          mismatches;
  int          pixels_seen;
  int          bytes_sent;
  longint      cycle_count;
  bit          quiet_tail;
  byte_row_t   directed[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit: a watchdog counts clock edges and ends a hung run with a
  // mismatch report.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp_dim(logic [14:0] v);
    if (v < 1) return 1;
    if (v > bmpd_pkg::MAX_DIMENSION) return bmpd_pkg::MAX_DIMENSION;
    return v;
  endfunction

  // Scale one masked channel to 8 bits with rounding.
  function automatic logic [7:0] scale_channel(logic [31:0] pix, logic [31:0] mask);
    int unsigned sh;
    logic [31:0] m, v;
    logic [63:0] t;
    if (mask == 0) return 8'd255;
    sh = 0;
    while (mask[sh] == 1'b0 && sh < 31) sh++;
    m = mask >> sh;
    v = (pix & mask) >> sh;
    t = 64'(v) * 255 + 64'(m / 2);
    return 8'(t / m);
  endfunction

  // Advance the decoder shadow by one byte; queue the pixel it completes.
  function automatic void decode_byte(logic [7:0] b);
    int unsigned w, h, bpp, rw;
    logic [31:0] pix;
    rgba_pixel_t px;
    w = clamp_dim(img_w);
    h = clamp_dim(img_h);
    bpp = (img_fmt == bmpd_pkg::FMT_BGR24) ? 3 : 4;
    if (pad_left != 0) begin
      pad_left = (pad_left - 1) & 3;
      return;
    end
    if (byte_pos < bpp - 1) begin
      partial = (partial | (b << (8 * byte_pos))) & 24'hFFFFFF;
      byte_pos = (byte_pos + 1) & 3;
      return;
    end
    if (bpp == 3) pix = (partial & 16'hFFFF) | (32'(b) << 16);
    else pix = (partial & 24'hFFFFFF) | (32'(b) << 24);
    byte_pos = 0;
    partial = 0;
    if (img_fmt == bmpd_pkg::FMT_BGR24 || img_fmt == bmpd_pkg::FMT_BGRA32) begin
      px.red = pix[23:16];
      px.green = pix[15:8];
      px.blue = pix[7:0];
      px.alpha = (img_fmt == bmpd_pkg::FMT_BGR24) ? 8'd255 : pix[31:24];
    end else begin
      px.red = scale_channel(pix, mask_r);
      px.green = scale_channel(pix, mask_g);
      px.blue = scale_channel(pix, mask_b);
      px.alpha = scale_channel(pix, mask_a);
    end
    rw = (row_cnt < h) ? row_cnt : h - 1;
    if (!img_top_down) rw = h - 1 - rw;
    px.row = 14'(rw);
    px.col = 14'(col_cnt);
    px.last = 1'b0;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      pad_left = (4 - ((w * bpp) & 3)) & 3;
      if (row_cnt + 1 >= h) begin
        row_cnt = 0;
        px.last = 1'b1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
    pending_pixels.push_back(px);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bmpd_pkg::REG_WIDTH: img_w = val[14:0];
      bmpd_pkg::REG_HEIGHT: img_h = val[14:0];
      bmpd_pkg::REG_TOP_DOWN: img_top_down = val[0];
      bmpd_pkg::REG_FORMAT: img_fmt = val[1:0];
      bmpd_pkg::REG_RED_MASK: mask_r = val;
      bmpd_pkg::REG_GREEN_MASK: mask_g = val;
      bmpd_pkg::REG_BLUE_MASK: mask_b = val;
      default: mask_a = val;
    endcase
  endtask

  task automatic cfg_image(int w, int h, bit td, logic [1:0] fmt,
                           logic [31:0] mr, logic [31:0] mg, logic [31:0] mb,
                           logic [31:0] ma);
    cfg_write(bmpd_pkg::REG_WIDTH, w);
    cfg_write(bmpd_pkg::REG_HEIGHT, h);
    cfg_write(bmpd_pkg::REG_TOP_DOWN, td);
    cfg_write(bmpd_pkg::REG_FORMAT, 32'(fmt));
    cfg_write(bmpd_pkg::REG_RED_MASK, mr);
    cfg_write(bmpd_pkg::REG_GREEN_MASK, mg);
    cfg_write(bmpd_pkg::REG_BLUE_MASK, mb);
    cfg_write(bmpd_pkg::REG_ALPHA_MASK, ma);
  endtask

  // Hold until every expected pixel is out, then let the back end settle
  // (a padding byte or a half-built pixel leaves nothing to wait for).
  task automatic drain_pipe();
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Send one byte as a transaction, with an occasional idle burst first.
  task automatic send_byte(logic [7:0] b);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send n_bytes random bytes, which need not fill whole images and can leave
  // the counters mid-image, which the next drained setting wraps through.
  task automatic random_images(int n_bytes);
    int cnt;
    cnt = 0;
    while (cnt < n_bytes) begin
      send_byte(8'($urandom));
      cnt++;
    end
    idle_input();
  endtask

  // Result side: random stall bursts, compare every transaction.
  initial begin
    rgba_pixel_t want;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          $error("pixel out with none expected");
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_red !== want.red) begin
            $error("red: expected %0d actual %0d", want.red, out_red);
            mismatches++;
          end
          if (out_green !== want.green) begin
            $error("green: expected %0d actual %0d", want.green, out_green);
            mismatches++;
          end
          if (out_blue !== want.blue) begin
            $error("blue: expected %0d actual %0d", want.blue, out_blue);
            mismatches++;
          end
          if (out_alpha !== want.alpha) begin
            $error("alpha: expected %0d actual %0d", want.alpha, out_alpha);
            mismatches++;
          end
          if (out_dest_row !== want.row) begin
            $error("dest_row: expected %0d actual %0d", want.row, out_dest_row);
            mismatches++;
          end
          if (out_dest_col !== want.col) begin
            $error("dest_col: expected %0d actual %0d", want.col, out_dest_col);
            mismatches++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel: expected %0d actual %0d", want.last, out_last_pixel);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic rgba_pixel_t pixel(int r, int g, int b, int a, int row,
                                        int col, bit last);
    rgba_pixel_t p;
    p = '{8'(r), 8'(g), 8'(b), 8'(a), 14'(row), 14'(col), last};
    return p;
  endfunction

  function automatic void add_row(logic [7:0] d, bit typed, rgba_pixel_t p);
    byte_row_t e;
    e.data = d;
    e.typed = typed;
    e.want = p;
    directed.push_back(e);
  endfunction

  initial begin
    int i;
    int phase;
    int w, h;
    logic [1:0] fmt;
    rgba_pixel_t none;
    none = '0;
    mismatches = 0;
    pixels_seen = 0;
    bytes_sent = 0;
    quiet_tail = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    img_w = 1; img_h = 1; img_top_down = 0; img_fmt = bmpd_pkg::FMT_BGR24;
    mask_r = bmpd_pkg::RED_MASK_RST; mask_g = bmpd_pkg::GREEN_MASK_RST;
    mask_b = bmpd_pkg::BLUE_MASK_RST; mask_a = bmpd_pkg::ALPHA_MASK_RST;
    byte_pos = 0; partial = 0; col_cnt = 0; row_cnt = 0; pad_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: 1x1 BGR24, one padding byte per row.
    // Extremes 0x00 and 0xFF, then a mixed pixel.
    add_row(8'h00, 0, none); add_row(8'h00, 0, none);
    add_row(8'h00, 1, pixel(0, 0, 0, 255, 0, 0, 1));
    add_row(8'hAB, 0, none);
    add_row(8'hFF, 0, none); add_row(8'hFF, 0, none);
    add_row(8'hFF, 1, pixel(255, 255, 255, 255, 0, 0, 1));
    add_row(8'h5A, 0, none);
    add_row(8'h11, 0, none); add_row(8'h22, 0, none);
    add_row(8'h33, 1, pixel(8'h33, 8'h22, 8'h11, 255, 0, 0, 1));
    add_row(8'h00, 0, none);
    foreach (directed[k]) begin
      send_byte(directed[k].data);
      if (directed[k].typed && pending_pixels.size() != 0 &&
          pending_pixels[$] !== directed[k].want) begin
        $error("table row %0d: predicted pixel differs from typed value", k);
        mismatches++;
      end
    end
    idle_input();
    drain_pipe();

    // BGRA 1x2 bottom-up and bitfields 2x1 with zero and odd masks.
    cfg_image(1, 2, 0, bmpd_pkg::FMT_BGRA32, bmpd_pkg::RED_MASK_RST,
              bmpd_pkg::GREEN_MASK_RST, bmpd_pkg::BLUE_MASK_RST,
              bmpd_pkg::ALPHA_MASK_RST);
    for (i = 0; i < 8; i++) send_byte(i[0] ? 8'hFF : 8'h80);
    idle_input();
    drain_pipe();
    cfg_image(2, 1, 1, 2'd3, 32'h0000_0000, 32'h8000_0001, 32'h0000_07E0,
              32'hFFFF_FFFF);
    for (i = 0; i < 8; i++) send_byte(8'($urandom));
    idle_input();
    drain_pipe();

    // Pressure: send a few pixels, then hold until all have come out.
    cfg_image(3, 3, 0, bmpd_pkg::FMT_BGR24, bmpd_pkg::RED_MASK_RST,
              bmpd_pkg::GREEN_MASK_RST, bmpd_pkg::BLUE_MASK_RST,
              bmpd_pkg::ALPHA_MASK_RST);
    for (i = 0; i < 12; i++) send_byte(8'($urandom));
    idle_input();
    while (pending_pixels.size() != 0) @(posedge clk);
    for (i = 0; i < 24; i++) send_byte(8'($urandom));
    idle_input();
    drain_pipe();

    // Random phases: mostly small images in every format, two extreme sizes.
    for (phase = 0; phase < 12; phase++) begin
      fmt = 2'($urandom_range(0, 3));
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 4);
      if (phase == 5) begin
        w = 16384; h = 16384; fmt = bmpd_pkg::FMT_BGR24;
      end
      if (phase == 6) begin
        w = 32767; h = 0; fmt = bmpd_pkg::FMT_BGRA32;
      end
      if (phase == 11) quiet_tail = 1'b1;
      cfg_image(w, h, $urandom_range(0, 1), fmt, $urandom, $urandom,
                ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                ($urandom_range(0, 1) == 0) ? 32'h0000_F000 : $urandom);
      random_images((fmt >= bmpd_pkg::FMT_BITFIELDS) ? 50 : 90);
      drain_pipe();
    end

    $display("Covered %0d bytes and %0d pixels over all formats, both row orders,",
             bytes_sent, pixels_seen);
    $display("clamped and extreme image sizes and masks from zero to all ones.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
